FILE: design/mtfw_pkg.sv
// mtfw_pkg: shared types and codes for the move-to-front window list
// request/response beat structs, request and status codes, cell control
// no dependencies
`timescale 1ns / 1ps

package mtfw_pkg;

  // default list depth
  localparam int unsigned DefaultCapacity = 16;

  localparam int unsigned IdWidth     = 16;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned ReqWidth    = 2;
  localparam int unsigned StatusWidth = 2;

  // request kinds
  typedef enum logic [ReqWidth-1:0] {
    REQ_OPEN   = 2'd0,
    REQ_SWITCH = 2'd1,
    REQ_CLOSE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  // response status codes
  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // what a cell loads on a commit cycle
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD_LEFT  = 2'd1,
    CELL_LOAD_RIGHT = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic     cmp_en;
    cell_op_e op;
  } cell_ctrl_t;

  // input beat
  typedef struct packed {
    logic [ReqWidth-1:0] req_type;
    logic [IdWidth-1:0]  window_id;
  } req_t;

  // output beat
  typedef struct packed {
    logic [IdWidth-1:0]     front_id;
    logic [CountWidth-1:0]  entry_count;
    logic [StatusWidth-1:0] status;
  } rsp_t;

endpackage

FILE: design/mtfw_cell.sv
// mtfw_cell: one list slot, holds an id and a registered match flag
// shifts toward either neighbor on command
// depends on mtfw_pkg
`timescale 1ns / 1ps

module mtfw_cell (
  input  logic                        clk_i,
  input  mtfw_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        valid_i,
  input  logic [mtfw_pkg::IdWidth-1:0] req_id_i,
  input  logic [mtfw_pkg::IdWidth-1:0] left_id_i,
  input  logic [mtfw_pkg::IdWidth-1:0] right_id_i,
  output logic [mtfw_pkg::IdWidth-1:0] id_o,
  output logic                        hit_o
);
  import mtfw_pkg::*;

  logic [IdWidth-1:0] id_q, id_d;
  logic               hit_q, hit_d;

  // slot contents move left, right or stay
  always_comb begin
    case (ctrl_i.op)
      CELL_LOAD_LEFT:  id_d = left_id_i;
      CELL_LOAD_RIGHT: id_d = right_id_i;
      default:         id_d = id_q;
    endcase
  end

  // compare against the pending request id
  assign hit_d = ctrl_i.cmp_en ? (valid_i && (id_q == req_id_i)) : hit_q;

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    hit_q <= hit_d;
  end

  assign id_o  = id_q;
  assign hit_o = hit_q;

endmodule

FILE: design/move_to_front_window_list.sv
// move_to_front_window_list: top level of the move-to-front window list
// a row of mtfw_cell slots plus the request sequencer and output register
// depends on mtfw_pkg and mtfw_cell
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid_i/in_ready_o carries one request beat (req_type,
//   window_id). Output channel out_valid_o/out_ready_i returns one response
//   beat per request (front_id, entry_count, status), in request order.
//   Each request passes a match state (S_MATCH), where every slot compares its
//   id with the request in parallel and registers a match flag, and then a
//   commit state (S_APPLY), where the first match is picked out of the flag
//   vector and the slots shift toward or away from the front. The response is
//   loaded into the output register on the commit cycle, after the request
//   latch and the registered match flags. A new request is accepted on the
//   commit cycle, so the list takes the next request while committing the last.
//   The commit waits while the output register still holds a beat that the
//   receiver has not taken; no request is accepted during that wait.
//   Reset empties the list (count zero) and clears the handshake state;
//   slot contents are not cleared, they are never read past the count.
//   Ids may repeat; switch and close act on the copy nearest the front.

module move_to_front_window_list #(
  parameter int unsigned CAPACITY = mtfw_pkg::DefaultCapacity
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mtfw_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mtfw_pkg::rsp_t out_data_o
);
  import mtfw_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  state_e state_q, state_d;

  req_t            req_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  rsp_t            out_data_q;

  logic out_free, commit, accept;

  logic [CAPACITY-1:0] hit, first, below, valid;
  logic                found;
  logic [IdWidth-1:0]  cell_id [CAPACITY];
  cell_ctrl_t          cell_ctrl [CAPACITY];

  logic [IdWidth-1:0] front_d;
  status_e            status_d;
  logic               full;

  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == S_APPLY) && out_free;
  assign in_ready_o = (state_q == S_IDLE) || commit;
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_MATCH;
      S_MATCH: state_d = S_APPLY;
      S_APPLY: begin
        if (out_free) state_d = in_valid_i ? S_MATCH : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
  end

  // first match in the flag vector
  assign found = |hit;
  assign first = hit & (~hit + CAPACITY'(1));
  assign below = first - CAPACITY'(1);
  assign full  = (count_q >= CntW'(CAPACITY));

  // per-slot commands
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].cmp_en = (state_q == S_MATCH);
      cell_ctrl[i].op     = CELL_HOLD;
      if (commit) begin
        case (req_type_e'(req_q.req_type))
          REQ_OPEN: begin
            if (!full) cell_ctrl[i].op = CELL_LOAD_LEFT;
          end
          REQ_SWITCH: begin
            if (found && (below[i] || first[i])) cell_ctrl[i].op = CELL_LOAD_LEFT;
          end
          REQ_CLOSE: begin
            if (found && !below[i]) cell_ctrl[i].op = CELL_LOAD_RIGHT;
          end
          default: cell_ctrl[i].op = CELL_HOLD;
        endcase
      end
    end
  end

  // slot row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [IdWidth-1:0] left_id, right_id;

    assign valid[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_head
      assign left_id = req_q.window_id;
    end else begin : g_body
      assign left_id = cell_id[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_id = '0;
    end else begin : g_inner
      assign right_id = cell_id[g+1];
    end

    mtfw_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[g]),
      .valid_i    (valid[g]),
      .req_id_i   (req_q.window_id),
      .left_id_i  (left_id),
      .right_id_i (right_id),
      .id_o       (cell_id[g]),
      .hit_o      (hit[g])
    );
  end

  // count, front and status after the request
  always_comb begin
    count_d  = count_q;
    front_d  = cell_id[0];
    status_d = ST_OK;
    case (req_type_e'(req_q.req_type))
      REQ_OPEN: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
          front_d = req_q.window_id;
        end
      end
      REQ_SWITCH: begin
        if (found) front_d = req_q.window_id;
        else       status_d = ST_NOT_FOUND;
      end
      REQ_CLOSE: begin
        if (found) begin
          count_d = count_q - CntW'(1);
          if (first[0]) front_d = cell_id[1];
          if (count_q == CntW'(1)) status_d = ST_EMPTY;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: status_d = ST_OK;
    endcase
    if (count_d == '0) front_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit) begin
      count_q <= count_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q.front_id    <= front_d;
      out_data_q.entry_count <= CountWidth'(count_d);
      out_data_q.status      <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
